### design/tsps_pkg.sv
package tsps_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned ScoreW = 16;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned ProdW  = 32;

  // Configuration register widths and reset values.
  localparam int unsigned WinRegW  = 6;
  localparam int unsigned KeepRegW = 4;
  localparam logic [WinRegW-1:0]  WinReset  = 6'd8;
  localparam logic [KeepRegW-1:0] KeepReset = 4'd8;

  // APB geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxWindowDef = 32;
  localparam int unsigned MaxKeepDef   = 8;

  typedef enum logic [0:0] {
    REG_WINDOW = 1'b0,
    REG_KEEP   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_OFFER,
    ST_RANK,
    ST_EMIT
  } state_e;

  // Commands from the sequencer to the span table.
  typedef struct packed {
    logic weak_load;
    logic offer;
    logic rank_en;
    logic clear;
  } tbl_cmd_t;

endpackage

### design/tsps_in_if.sv
interface tsps_in_if import tsps_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] start_score;
  logic [ScoreW-1:0] end_score;
  logic              last_item;

  modport source (output valid, start_score, end_score, last_item, input ready);
  modport sink (input valid, start_score, end_score, last_item, output ready);
endinterface

### design/tsps_out_if.sv
interface tsps_out_if import tsps_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  span_start;
  logic [IdxW-1:0]  span_end;
  logic [ProdW-1:0] span_score;
  logic             entry_valid;
  logic             index_overflow;
  logic             final_result;

  modport source (output valid, span_start, span_end, span_score, entry_valid,
                  index_overflow, final_result, input ready);
  modport sink (input valid, span_start, span_end, span_score, entry_valid,
                index_overflow, final_result, output ready);
endinterface

### design/tsps_ram.sv
module tsps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/tsps_cfg.sv
module tsps_cfg import tsps_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned MaxKeep   = MaxKeepDef,
  localparam int unsigned WinEffW  = $clog2(MaxWindow + 1),
  localparam int unsigned CntW     = $clog2(MaxKeep + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PAddrW-1:0]  paddr_i,
  input  logic [PDataW-1:0]  pwdata_i,
  output logic [PDataW-1:0]  prdata_o,
  output logic [WinEffW-1:0] win_eff_o,
  output logic [CntW-1:0]    keep_eff_o
);

  logic [WinRegW-1:0]  window_q;
  logic [KeepRegW-1:0] keep_q;
  reg_idx_e            idx;
  logic                wr_en;

  // Low address bits are not decoded.
  assign idx   = reg_idx_e'(paddr_i[2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinReset;
      keep_q   <= KeepReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW: window_q <= pwdata_i[WinRegW-1:0];
        REG_KEEP:   keep_q   <= pwdata_i[KeepRegW-1:0];
        default:    window_q <= window_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW: prdata_o = PDataW'(window_q);
      REG_KEEP:   prdata_o = PDataW'(keep_q);
      default:    prdata_o = '0;
    endcase
  end

  // Out-of-range settings are clamped into the supported range.
  always_comb begin
    if (window_q == '0) begin
      win_eff_o = WinEffW'(1);
    end else if (int'(window_q) > int'(MaxWindow)) begin
      win_eff_o = WinEffW'(MaxWindow);
    end else begin
      win_eff_o = WinEffW'(window_q);
    end
  end

  always_comb begin
    if (keep_q == '0) begin
      keep_eff_o = CntW'(1);
    end else if (int'(keep_q) > int'(MaxKeep)) begin
      keep_eff_o = CntW'(MaxKeep);
    end else begin
      keep_eff_o = CntW'(keep_q);
    end
  end

endmodule

### design/tsps_table.sv
module tsps_table import tsps_pkg::*; #(
  parameter int unsigned MaxKeep = MaxKeepDef,
  localparam int unsigned KeyW   = (MaxKeep > 1) ? $clog2(MaxKeep) : 1,
  localparam int unsigned CntW   = $clog2(MaxKeep + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_cmd_t         cmd_i,
  input  logic [CntW-1:0]  keep_eff_i,
  input  logic [ProdW-1:0] cand_score_i,
  input  logic [IdxW-1:0]  cand_start_i,
  input  logic [IdxW-1:0]  cand_end_i,
  input  logic [KeyW-1:0]  rank_sel_i,
  input  logic [CntW-1:0]  emit_idx_i,
  output logic             sel_valid_o,
  output logic [IdxW-1:0]  sel_start_o,
  output logic [IdxW-1:0]  sel_end_o,
  output logic [ProdW-1:0] sel_score_o
);

  logic [ProdW-1:0] score_q [MaxKeep];
  logic [IdxW-1:0]  start_q [MaxKeep];
  logic [IdxW-1:0]  end_q   [MaxKeep];
  logic [CntW-1:0]  rank_q  [MaxKeep];
  logic [CntW-1:0]  count_q;
  logic [MaxKeep-1:0] weak_oh_d, weak_oh_q;
  logic [MaxKeep-1:0] wr_en;
  logic [MaxKeep-1:0] rank_inc;
  logic [MaxKeep-1:0] hit;
  logic [ProdW-1:0] weak_score;
  logic             do_fill;
  logic             do_replace;
  logic [ProdW-1:0] ref_score;
  logic [IdxW-1:0]  ref_start;
  logic [IdxW-1:0]  ref_end;
  logic             ref_valid;

  // The weakest slot is the lowest score, the lowest slot among equals.
  always_comb begin
    for (int i = 0; i < int'(MaxKeep); i++) begin
      weak_oh_d[i] = (i < int'(count_q));
      for (int j = 0; j < int'(MaxKeep); j++) begin
        if (j != i && j < int'(count_q)) begin
          if (j < i) begin
            weak_oh_d[i] = weak_oh_d[i] && (score_q[i] < score_q[j]);
          end else begin
            weak_oh_d[i] = weak_oh_d[i] && (score_q[i] <= score_q[j]);
          end
        end
      end
    end
  end

  always_comb begin
    weak_score = '0;
    for (int i = 0; i < int'(MaxKeep); i++) begin
      weak_score = weak_score | (weak_oh_q[i] ? score_q[i] : '0);
    end
  end

  assign do_fill    = cmd_i.offer && (count_q < keep_eff_i);
  assign do_replace = cmd_i.offer && !(count_q < keep_eff_i) && (count_q != '0)
                      && (cand_score_i > weak_score);

  always_comb begin
    for (int i = 0; i < int'(MaxKeep); i++) begin
      wr_en[i] = (do_fill && (count_q[KeyW-1:0] == KeyW'(i)))
                 || (do_replace && weak_oh_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(MaxKeep); i++) begin
      if (wr_en[i]) begin
        score_q[i] <= cand_score_i;
        start_q[i] <= cand_start_i;
        end_q[i]   <= cand_end_i;
      end
    end
    if (cmd_i.weak_load) begin
      weak_oh_q <= weak_oh_d;
    end
  end

  // Ranking sweep: one reference entry per cycle is compared with every slot.
  assign ref_score = score_q[rank_sel_i];
  assign ref_start = start_q[rank_sel_i];
  assign ref_end   = end_q[rank_sel_i];
  assign ref_valid = (CntW'(rank_sel_i) < count_q);

  always_comb begin
    for (int i = 0; i < int'(MaxKeep); i++) begin
      if (ref_score != score_q[i]) begin
        rank_inc[i] = ref_valid && (ref_score > score_q[i]);
      end else if (ref_end != end_q[i]) begin
        rank_inc[i] = ref_valid && (ref_end < end_q[i]);
      end else begin
        rank_inc[i] = ref_valid && (ref_start < start_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < int'(MaxKeep); i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      count_q <= '0;
      for (int i = 0; i < int'(MaxKeep); i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (do_fill) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.rank_en) begin
        for (int i = 0; i < int'(MaxKeep); i++) begin
          if (rank_inc[i]) begin
            rank_q[i] <= rank_q[i] + CntW'(1);
          end
        end
      end
    end
  end

  // Result selection: the slot whose rank matches the result index.
  always_comb begin
    sel_start_o = '0;
    sel_end_o   = '0;
    sel_score_o = '0;
    for (int i = 0; i < int'(MaxKeep); i++) begin
      hit[i] = (i < int'(count_q)) && (rank_q[i] == emit_idx_i);
      sel_start_o = sel_start_o | (hit[i] ? start_q[i] : '0);
      sel_end_o   = sel_end_o   | (hit[i] ? end_q[i]   : '0);
      sel_score_o = sel_score_o | (hit[i] ? score_q[i] : '0);
    end
  end

  assign sel_valid_o = |hit;

endmodule

### design/topk_span_product_search.sv
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// in_i      | sink      | start_score, end_score, last_item
// out_o     | source    | span_start, span_end, span_score, entry_valid,
//           |           | index_overflow, final_result
// APB       | slave     | window_width at 0x0, keep_count at 0x4
//
// A step scores W starts, W being the number of starts scored (window_width,
// fewer near the start of a sequence): one shared multiplier and the slot table's
// compare unit handle the candidates one at a time. A step past the index
// range is taken without scoring. A last item adds a ranking pass over the MaxKeep
// slots and then emits the results one by one, held while out_o stalls. Reset is asynchronous and needs
// no clearing pass; input is taken again as soon as the sequencer is idle.
module topk_span_product_search import tsps_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned MaxKeep   = MaxKeepDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready,
  tsps_in_if.sink           in_i,
  tsps_out_if.source        out_o
);

  localparam int unsigned AddrW   = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned WinEffW = $clog2(MaxWindow + 1);
  localparam int unsigned KeyW    = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;
  localparam int unsigned CntW    = $clog2(MaxKeep + 1);

  state_e state_q, state_d;

  logic [WinEffW-1:0] win_eff;
  logic [CntW-1:0]    keep_eff;

  logic [IdxW-1:0]   t_q;
  logic              full_q;
  logic              ovf_q;
  logic [AddrW-1:0]  wptr_q;
  logic [AddrW-1:0]  rptr_q, rptr_d;
  logic [IdxW-1:0]   s_q;
  logic [IdxW-1:0]   lo_q;
  logic [ScoreW-1:0] ev_q;
  logic              last_q;
  logic [ProdW-1:0]  prod_q;
  logic [KeyW-1:0]   j_q;
  logic [CntW-1:0]   o_q;

  logic              out_valid_q;
  logic [IdxW-1:0]   out_start_q;
  logic [IdxW-1:0]   out_end_q;
  logic [ProdW-1:0]  out_score_q;
  logic              out_entry_q;
  logic              out_ovf_q;
  logic              out_final_q;

  logic [ScoreW-1:0] ram_rdata;
  logic [IdxW:0]     t_plus1;
  logic [IdxW:0]     lo_wide;

  logic              in_ready;
  logic              accept;
  logic              ram_we;
  logic              step_done;
  logic              out_load;
  logic              last_result;
  tbl_cmd_t          tbl_cmd;

  logic              sel_valid;
  logic [IdxW-1:0]   sel_start;
  logic [IdxW-1:0]   sel_end;
  logic [ProdW-1:0]  sel_score;

  tsps_cfg #(
    .MaxWindow (MaxWindow),
    .MaxKeep   (MaxKeep)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .win_eff_o  (win_eff),
    .keep_eff_o (keep_eff)
  );

  assign pready = 1'b1;

  tsps_ram #(
    .Width (ScoreW),
    .Depth (MaxWindow)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (in_i.start_score),
    .raddr_i (rptr_d),
    .rdata_o (ram_rdata)
  );

  tsps_table #(
    .MaxKeep (MaxKeep)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (tbl_cmd),
    .keep_eff_i   (keep_eff),
    .cand_score_i (prod_q),
    .cand_start_i (s_q),
    .cand_end_i   (t_q),
    .rank_sel_i   (j_q),
    .emit_idx_i   (o_q),
    .sel_valid_o  (sel_valid),
    .sel_start_o  (sel_start),
    .sel_end_o    (sel_end),
    .sel_score_o  (sel_score)
  );

  assign accept      = in_i.valid && in_ready;
  assign last_result = (o_q == keep_eff - CntW'(1));

  // Oldest start still inside the window.
  assign t_plus1 = {1'b0, t_q} + (IdxW+1)'(1);
  assign lo_wide = (t_plus1 >= (IdxW+1)'(win_eff)) ? t_plus1 - (IdxW+1)'(win_eff) : '0;

  // The read address is driven from rptr_d, ahead of its register, so that data arrives in ST_MUL.
  always_comb begin
    rptr_d = rptr_q;
    if (accept) begin
      rptr_d = wptr_q;
    end else if (state_q == ST_OFFER && !step_done) begin
      rptr_d = (rptr_q == '0) ? AddrW'(MaxWindow - 1) : rptr_q - AddrW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!full_q) begin
            state_d = ST_READ;
          end else if (in_i.last_item) begin
            state_d = ST_RANK;
          end
        end
      end
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_OFFER;
      ST_OFFER: begin
        if (s_q != lo_q) begin
          state_d = ST_MUL;
        end else if (last_q) begin
          state_d = ST_RANK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RANK: begin
        if (j_q == KeyW'(MaxKeep - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && last_result) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    in_ready          = 1'b0;
    ram_we            = 1'b0;
    step_done         = 1'b0;
    out_load          = 1'b0;
    tbl_cmd           = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_i.valid && !full_q;
      end
      ST_READ: begin
      end
      ST_MUL: begin
        tbl_cmd.weak_load = 1'b1;
      end
      ST_OFFER: begin
        tbl_cmd.offer = 1'b1;
        step_done     = (s_q == lo_q);
      end
      ST_RANK: begin
        tbl_cmd.rank_en = 1'b1;
      end
      ST_EMIT: begin
        out_load      = !out_valid_q || out_o.ready;
        tbl_cmd.clear = out_load && last_result;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      full_q      <= 1'b0;
      ovf_q       <= 1'b0;
      wptr_q      <= '0;
      j_q         <= '0;
      o_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && full_q) begin
        ovf_q <= 1'b1;
      end
      if (step_done) begin
        wptr_q <= (wptr_q == AddrW'(MaxWindow - 1)) ? '0 : wptr_q + AddrW'(1);
        if (t_q == '1) begin
          full_q <= 1'b1;
        end else begin
          t_q <= t_q + IdxW'(1);
        end
      end
      if (state_q == ST_RANK) begin
        j_q <= (j_q == KeyW'(MaxKeep - 1)) ? '0 : j_q + KeyW'(1);
      end
      if (out_load) begin
        o_q <= last_result ? '0 : o_q + CntW'(1);
      end
      if (tbl_cmd.clear) begin
        t_q    <= '0;
        full_q <= 1'b0;
        ovf_q  <= 1'b0;
        wptr_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q <= rptr_d;
    if (accept) begin
      ev_q   <= in_i.end_score;
      last_q <= in_i.last_item;
      s_q    <= t_q;
      lo_q   <= lo_wide[IdxW-1:0];
    end
    if (state_q == ST_OFFER && !step_done) begin
      s_q <= s_q - IdxW'(1);
    end
    if (state_q == ST_MUL) begin
      prod_q <= {{(ProdW-ScoreW){1'b0}}, ram_rdata} * {{(ProdW-ScoreW){1'b0}}, ev_q};
    end
    if (out_load) begin
      out_start_q <= sel_start;
      out_end_q   <= sel_end;
      out_score_q <= sel_score;
      out_entry_q <= sel_valid;
      out_ovf_q   <= ovf_q;
      out_final_q <= last_result;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.span_start     = out_start_q;
  assign out_o.span_end       = out_end_q;
  assign out_o.span_score     = out_score_q;
  assign out_o.entry_valid    = out_entry_q;
  assign out_o.index_overflow = out_ovf_q;
  assign out_o.final_result   = out_final_q;

endmodule

### design/tsps_checker.sv
module tsps_checker import tsps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_last_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ProdW-1:0] out_score_i,
  input logic             out_entry_i,
  input logic             out_final_i
);

  logic             out_xfer;
  logic             seen_valid_q;
  logic             seen_invalid_q;
  logic [ProdW-1:0] prev_score_q;

  assign out_xfer = out_valid_i && out_ready_i;

  // Tracks the results of the run in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_valid_q   <= 1'b0;
      seen_invalid_q <= 1'b0;
      prev_score_q   <= '0;
    end else if (out_xfer) begin
      if (out_final_i) begin
        seen_valid_q   <= 1'b0;
        seen_invalid_q <= 1'b0;
      end else if (out_entry_i) begin
        seen_valid_q <= 1'b1;
        prev_score_q <= out_score_i;
      end else begin
        seen_invalid_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i))
    else $error("result changed while stalled");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken while the table is being emitted");

  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_entry_i && seen_valid_q |-> out_score_i <= prev_score_q)
    else $error("results not in descending score order");

  a_valid_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_invalid_q |-> !out_entry_i)
    else $error("found span after an empty slot");

endmodule

bind topk_span_product_search tsps_checker u_tsps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_item),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_score_i (out_o.span_score),
  .out_entry_i (out_o.entry_valid),
  .out_final_i (out_o.final_result)
);

### test/topk_span_product_search_test.sv
`timescale 1ns / 1ps

module topk_span_product_search_test;
  import tsps_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned SettleCycles = 2 * MaxWindowDef + 2 + MaxKeepDef + 30;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandomSteps = 250;

  typedef struct packed {
    logic [IdxW-1:0]  span_start;
    logic [IdxW-1:0]  span_end;
    logic [ProdW-1:0] span_score;
    logic             entry_valid;
    logic             index_overflow;
    logic             final_result;
  } span_rec_t;

  class span_scoreboard;
    logic [ScoreW-1:0]  start_hist[MaxWindowDef];
    int unsigned        step_idx;
    bit                 idx_full;
    bit                 ovf;
    logic [ProdW-1:0]   best_sc[MaxKeepDef];
    logic [IdxW-1:0]    best_st[MaxKeepDef];
    logic [IdxW-1:0]    best_en[MaxKeepDef];
    int unsigned        best_cnt;
    logic [WinRegW-1:0] win_reg;
    logic [KeepRegW-1:0] keep_reg;
    span_rec_t          awaited[$];
    int unsigned        errors;

    function new();
      win_reg = WinReset;
      keep_reg = KeepReset;
      errors = 0;
      foreach (start_hist[i]) start_hist[i] = '0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      step_idx = 0;
      idx_full = 0;
      ovf = 0;
      best_cnt = 0;
      foreach (best_sc[i]) begin
        best_sc[i] = '0;
        best_st[i] = '0;
        best_en[i] = '0;
      end
    endfunction

    function void set_register(reg_idx_e idx, logic [PDataW-1:0] value);
      if (idx == REG_WINDOW) win_reg = value[WinRegW-1:0];
      else keep_reg = value[KeepRegW-1:0];
    endfunction

    function int unsigned keep_limit();
      if (keep_reg == 0) return 1;
      if (keep_reg > MaxKeepDef) return MaxKeepDef;
      return keep_reg;
    endfunction

    function void offer(int unsigned s, int unsigned t, logic [ProdW-1:0] score);
      int unsigned low_slot;
      if (best_cnt < keep_limit() && best_cnt < MaxKeepDef) begin
        best_sc[best_cnt] = score;
        best_st[best_cnt] = s[IdxW-1:0];
        best_en[best_cnt] = t[IdxW-1:0];
        best_cnt++;
        return;
      end
      if (best_cnt == 0) return;
      // The weakest slot is the lowest score, the lowest slot among equals.
      low_slot = 0;
      for (int unsigned i = 1; i < best_cnt; i++)
        if (best_sc[i] < best_sc[low_slot]) low_slot = i;
      if (score > best_sc[low_slot]) begin
        best_sc[low_slot] = score;
        best_st[low_slot] = s[IdxW-1:0];
        best_en[low_slot] = t[IdxW-1:0];
      end
    endfunction

    function void note_step(logic [ScoreW-1:0] sv, logic [ScoreW-1:0] ev, bit last);
      int unsigned t, w, lo, s, n, k, j, cur, prev;
      int unsigned order[MaxKeepDef];
      bit moves;
      span_rec_t rec;
      if (idx_full) begin
        ovf = 1;
      end else begin
        t = step_idx;
        w = (win_reg == 0) ? 1 : (win_reg > MaxWindowDef) ? MaxWindowDef : win_reg;
        lo = (t + 1 >= w) ? t + 1 - w : 0;
        start_hist[t % MaxWindowDef] = sv;
        // Starts are offered newest first.
        s = t + 1;
        while (s > lo) begin
          s--;
          offer(s, t, ProdW'(start_hist[s % MaxWindowDef]) * ProdW'(ev));
        end
        if (t >= 32'hFFFF) idx_full = 1;
        else step_idx = t + 1;
      end
      if (!last) return;

      n = best_cnt;
      for (int unsigned i = 0; i < n; i++) order[i] = i;
      for (int unsigned i = 1; i < n; i++) begin
        cur = order[i];
        j = i;
        while (j > 0) begin
          prev = order[j-1];
          if (best_sc[cur] != best_sc[prev]) moves = best_sc[cur] > best_sc[prev];
          else if (best_en[cur] != best_en[prev]) moves = best_en[cur] < best_en[prev];
          else moves = best_st[cur] < best_st[prev];
          if (!moves) break;
          order[j] = prev;
          j--;
        end
        order[j] = cur;
      end

      k = keep_limit();
      for (int unsigned i = 0; i < k; i++) begin
        rec = '0;
        if (i < n) begin
          rec.span_start = best_st[order[i]];
          rec.span_end = best_en[order[i]];
          rec.span_score = best_sc[order[i]];
          rec.entry_valid = 1'b1;
        end
        rec.index_overflow = ovf;
        rec.final_result = (i + 1 == k);
        awaited = {awaited, rec};
      end
      clear_sequence();
    endfunction

    function int unsigned differs(string field, logic [ProdW-1:0] want, logic [ProdW-1:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      return 1;
    endfunction

    function void check_result(span_rec_t got);
      span_rec_t want;
      if (awaited.size() == 0) begin
        $display("%0t: span result with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      errors += differs("span_start", want.span_start, got.span_start);
      errors += differs("span_end", want.span_end, got.span_end);
      errors += differs("span_score", want.span_score, got.span_score);
      errors += differs("entry_valid", want.entry_valid, got.entry_valid);
      errors += differs("index_overflow", want.index_overflow, got.index_overflow);
      errors += differs("final_result", want.final_result, got.final_result);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  tsps_in_if  in_bus ();
  tsps_out_if out_bus ();

  topk_span_product_search DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  span_scoreboard sb;
  bit             idle_on;
  bit             hold_pending;
  int unsigned    quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Scores lean towards the extremes and small values so that ties occur often.
  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ScoreW'($urandom_range(1, 3));
      3: return 16'h8000;
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic logic [PDataW-1:0] pick_window();
    logic [PDataW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[WinRegW-1:0] = 0;
      1: v[WinRegW-1:0] = 1;
      2: v[WinRegW-1:0] = MaxWindowDef;
      3: v[WinRegW-1:0] = '1;
      4: v[WinRegW-1:0] = MaxWindowDef + 1;
      default: v[WinRegW-1:0] = $urandom_range(1, MaxWindowDef);
    endcase
    return v;
  endfunction

  function automatic logic [PDataW-1:0] pick_keep();
    logic [PDataW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 6))
      0: v[KeepRegW-1:0] = 0;
      1: v[KeepRegW-1:0] = 1;
      2: v[KeepRegW-1:0] = MaxKeepDef;
      3: v[KeepRegW-1:0] = '1;
      default: v[KeepRegW-1:0] = $urandom_range(1, MaxKeepDef);
    endcase
    return v;
  endfunction

  // Writes a register, then reads it back.
  task automatic configure(reg_idx_e idx, logic [PDataW-1:0] value);
    logic [PDataW-1:0] want;
    logic [PDataW-1:0] got;
    want = (idx == REG_WINDOW) ? PDataW'(value[WinRegW-1:0]) : PDataW'(value[KeepRegW-1:0]);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      $display("%0t: register %s readback, expected %h, actual %h", $time, idx.name(), want, got);
      sb.errors++;
    end
  endtask

  task automatic send_step(logic [ScoreW-1:0] sv, logic [ScoreW-1:0] ev, bit last);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.start_score = sv;
    in_bus.end_score = ev;
    in_bus.last_item = last;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_step(sv, ev, last);
  endtask

  // Lets the block drain and go idle before its registers are touched.
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall_left;
    out_bus.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        out_bus.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_pending = 0;
      end
      if (!idle_on) begin
        out_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_result({out_bus.span_start, out_bus.span_end, out_bus.span_score,
                       out_bus.entry_valid, out_bus.index_overflow, out_bus.final_result});
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("topk_span_product_search_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_steps;
    int unsigned seq_count;
    int unsigned seq_len;
    bit          first_phase;

    sb = new();
    quiet_cycles = 0;
    idle_on = 1;
    hold_pending = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.start_score = '0;
    in_bus.end_score = '0;
    in_bus.last_item = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: extremes of both scores and plenty of zero ties.
    send_step('1, '1, 0);
    send_step('0, '0, 0);
    send_step('1, '0, 0);
    send_step('0, '1, 0);
    send_step(16'd1, 16'd1, 1);
    // A single step leaves most slots empty.
    send_step(16'h1234, 16'h5678, 1);

    // Zero in both registers is taken as one.
    settle();
    configure(REG_WINDOW, 32'hFFFF_FFC0);
    configure(REG_KEEP, 32'h0000_0000);
    send_step('1, 16'd1, 0);
    send_step(16'd2, '1, 0);
    send_step(16'd7, 16'd7, 1);

    // Values above the limits are clipped.
    settle();
    configure(REG_WINDOW, 32'h0000_003F);
    configure(REG_KEEP, 32'h0000_000F);
    send_step(16'h8000, 16'h8000, 0);
    send_step('1, '1, 0);
    send_step(16'd1, '1, 0);
    send_step('1, 16'd1, 1);

    // The table is filled with ties, then keep_count drops below its fill.
    settle();
    configure(REG_WINDOW, 32'd4);
    configure(REG_KEEP, 32'd8);
    repeat (6) send_step(16'h0100, 16'h0100, 0);
    settle();
    configure(REG_KEEP, 32'd3);
    send_step(16'h0200, 16'h0100, 0);
    send_step(16'h0100, 16'h0100, 1);

    random_steps = 0;
    first_phase = 1;
    while (random_steps < RandomSteps) begin
      settle();
      if (first_phase || $urandom_range(0, 2) != 0) configure(REG_WINDOW, pick_window());
      if (first_phase || $urandom_range(0, 2) != 0) configure(REG_KEEP, pick_keep());
      idle_on = ($urandom_range(0, 3) != 0);
      seq_count = $urandom_range(1, 3);
      // In the first phase the receiver holds off while short sequences keep coming.
      if (first_phase) begin
        idle_on = 1;
        hold_pending = 1;
        seq_count = 5;
      end
      for (int unsigned q = 0; q < seq_count; q++) begin
        if (first_phase) seq_len = 2;
        else if ($urandom_range(0, 4) == 0) seq_len = $urandom_range(20, 70);
        else seq_len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < seq_len; i++) begin
          if (i == seq_len / 2 && seq_len > 4 && $urandom_range(0, 9) == 0) begin
            settle();
            configure(REG_KEEP, pick_keep());
          end
          send_step(pick_score(), pick_score(), i == seq_len - 1);
          random_steps++;
        end
      end
      first_phase = 0;
    end

    // A short sequence with a one-step window.
    settle();
    configure(REG_WINDOW, 32'd1);
    configure(REG_KEEP, 32'd8);
    idle_on = 1;
    send_step(16'h4000, 16'h4000, 0);
    send_step('1, 16'h0003, 0);
    send_step(16'h0005, '1, 1);

    settle();
    if (sb.errors == 0) begin
      $display("topk_span_product_search_test passed");
    end else begin
      $display("topk_span_product_search_test failed");
    end
    $finish;
  end

endmodule
